FILE: design/dri_pkg.sv
package dri_pkg;

  typedef enum logic [3:0] {
    ERR_NONE,
    ERR_INHIBIT,
    ERR_START_COORD,
    ERR_START_UNHOMED,
    ERR_START_OFFSETS,
    ERR_START_SPINDLE,
    ERR_STOP_COORD,
    ERR_STOP_SPINDLE,
    ERR_LOST_HOMING,
    ERR_OFFSETS_FINISH
  } err_t;

  typedef struct packed {
    logic       start_request;
    logic       quit_request;
    logic [7:0] inhibit_code;
    logic       motion_enabled;
    logic       all_homed;
    logic       coord_active;
    logic       offsets_enabled;
    logic       spindle_on;
  } in_item_t;

  typedef struct packed {
    logic in_dry_run;
    logic mode_active;
    logic finishing;
    err_t error_code;
    logic report_error;
    logic pose_capture;
    logic clear_motion_status;
    logic clear_dry_status;
    logic force_teleop;
    logic force_machine_off;
  } out_item_t;

  typedef struct packed {
    logic started;
    logic stopping;
    logic finished_phase;
    logic refusal_reported;
    logic indicator;
  } mode_state_t;

endpackage

FILE: design/dri_chan_if.sv
interface dri_in_if
  import dri_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dri_out_if
  import dri_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/dri_decide.sv
module dri_decide
  import dri_pkg::*;
(
  input  mode_state_t state_cur,
  input  in_item_t    item,
  output mode_state_t state_nxt,
  output out_item_t   result
);

  err_t start_err;
  err_t stop_err;
  err_t err;
  logic report;
  logic save;
  logic clr_dry;
  logic teleop;
  logic mach_off;
  logic st;

  always_comb begin
    state_nxt = state_cur;
    start_err = ERR_NONE;
    stop_err  = ERR_NONE;
    err       = ERR_NONE;
    report    = 1'b0;
    save      = 1'b0;
    clr_dry   = 1'b0;
    teleop    = 1'b0;
    mach_off  = 1'b0;
    st        = state_cur.started;

    if (state_cur.finished_phase) begin
      state_nxt.finished_phase = 1'b0;
      if (item.offsets_enabled) begin
        mach_off = 1'b1;
        err      = ERR_OFFSETS_FINISH;
        report   = 1'b1;
      end
    end else if (state_cur.stopping) begin
      state_nxt.stopping       = 1'b0;
      state_nxt.finished_phase = 1'b1;
      clr_dry                  = 1'b1;
    end else if (!item.motion_enabled) begin
      state_nxt.indicator = 1'b0;
      state_nxt.started   = 1'b0;
    end else if (!item.all_homed && st) begin
      state_nxt.indicator = 1'b0;
      state_nxt.started   = 1'b0;
      err                 = ERR_LOST_HOMING;
      report              = 1'b1;
    end else begin
      if (item.start_request) begin
        if (item.inhibit_code != 8'd0)          start_err = ERR_INHIBIT;
        else if (!st && item.coord_active)      start_err = ERR_START_COORD;
        else if (!item.all_homed)               start_err = ERR_START_UNHOMED;
        else if (item.offsets_enabled)          start_err = ERR_START_OFFSETS;
        else if (item.spindle_on)               start_err = ERR_START_SPINDLE;
      end
      if (start_err == ERR_NONE && item.quit_request && st) begin
        if (item.coord_active)    stop_err = ERR_STOP_COORD;
        else if (item.spindle_on) stop_err = ERR_STOP_SPINDLE;
      end

      if (start_err != ERR_NONE) begin
        err                        = start_err;
        state_nxt.indicator        = 1'b0;
        state_nxt.started          = 1'b0;
        report                     = !state_cur.refusal_reported;
        state_nxt.refusal_reported = 1'b1;
      end else if (stop_err != ERR_NONE) begin
        err                        = stop_err;
        report                     = !state_cur.refusal_reported;
        state_nxt.refusal_reported = 1'b1;
      end else begin
        save                       = item.start_request && !st;
        state_nxt.refusal_reported = 1'b0;
        if (item.quit_request && st) begin
          state_nxt.stopping = 1'b1;
          teleop             = 1'b1;
        end
        // stop wins over start
        state_nxt.started   = (st || item.start_request) && !item.quit_request;
        state_nxt.indicator = (st || item.start_request) && !item.quit_request;
      end
    end

    result.in_dry_run          = state_nxt.indicator;
    result.mode_active         = state_nxt.started || state_nxt.stopping
                                 || state_nxt.finished_phase;
    result.finishing           = state_nxt.finished_phase;
    result.error_code          = err;
    result.report_error        = report;
    result.pose_capture        = save;
    result.clear_motion_status = save;
    result.clear_dry_status    = clr_dry;
    result.force_teleop        = teleop;
    result.force_machine_off   = mach_off;
  end

endmodule

FILE: design/dry_run_mode_interlock_core.sv
// dry run mode interlock
// in_ch carries one servo tick per request: start/stop requests and machine
// status. out_ch returns exactly one result per tick with the mode flags, the
// refusal code, the report flag and the one-tick command pulses.
// the request is captured in an input register, evaluated by a short flag
// network against the mode state, and the result lands in an output register.
// the output register loads from the input register when the output is free;
// throughput is one request per cycle while out_ch.ready stays high.
// mode state advances when a request moves from the input register into the
// output register, so requests are evaluated strictly in arrival order.
// when the receiver stalls, the result holds in the output register and the
// input register still takes one more request; in_ch.ready drops only while
// both registers are full and out_ch.ready is low.
// rst_n (synchronous, active low) empties both registers and clears started,
// stopping, finish phase, refusal-reported and the indicator.
module dry_run_mode_interlock_core
  import dri_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  dri_in_if.sink   in_ch,
  dri_out_if.source out_ch
);

  logic        s1_valid_r;
  in_item_t    s1_item_r;
  logic        out_valid_r;
  out_item_t   out_item_r;
  mode_state_t state_r;
  mode_state_t state_nxt;
  out_item_t   result_nxt;
  logic        advance;

  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

  dri_decide u_decide (
    .state_cur (state_r),
    .item      (s1_item_r),
    .state_nxt (state_nxt),
    .result    (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_item_r <= in_ch.data;
    end
    if (advance) begin
      out_item_r <= result_nxt;
    end
  end

  // stopping and finish phase never overlap
  a_phase_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r.stopping && state_r.finished_phase))
    else $error("stopping and finish phase both set");

  a_stop_to_finish: assert property (@(posedge clk) disable iff (!rst_n)
    advance && state_r.stopping |=> state_r.finished_phase && !state_r.stopping)
    else $error("stopping tick did not enter finish phase");

  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && state_r.finished_phase |=> !state_r.finished_phase)
    else $error("finish phase lasted more than one tick");

  a_capture_with_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.pose_capture |->
      out_item_r.clear_motion_status && out_item_r.error_code == ERR_NONE)
    else $error("pose capture without status clear or with a refusal");

  a_machine_off_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.force_machine_off |->
      out_item_r.error_code == ERR_OFFSETS_FINISH && out_item_r.report_error)
    else $error("machine off without offsets-at-finish report");

endmodule
